// ===== rtl/ssf_pkg.sv =====
`default_nettype none
package ssf_pkg;

   localparam int POS_W   = 16;
   localparam int DIST_W  = 16;
   localparam int TOTAL_W = 22;
   localparam int STAT_W  = 2;
   localparam int RSP_W   = 56;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_RUN  = 1'b1;

   localparam logic [STAT_W-1:0] STATUS_SERVED  = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_FULL    = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_NOTHING = 2'd2;

   // One classified command handed from the front end to the engine.
   typedef struct packed {
      logic             is_run;
      logic [POS_W-1:0] position;
   } cmd_type;

endpackage
`default_nettype wire

// ===== rtl/ssf_front.sv =====
`default_nettype none
module ssf_front (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_tvalid,
   output logic                      req_tready,
   input  wire  [ssf_pkg::POS_W-1:0] req_tdata,
   input  wire  [0:0]                req_tuser,
   output logic                      cmd_valid,
   input  wire                       cmd_ready,
   output ssf_pkg::cmd_type          cmd
);

   // Two-entry queue between the stream input and the scheduling engine.
   ssf_pkg::cmd_type queue_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;
   logic             push, pop;
   ssf_pkg::cmd_type incoming;

   assign req_tready = (fill_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (fill_ff != 2'd0);
   assign pop        = cmd_valid && cmd_ready;
   assign cmd        = queue_ff[rd_ptr_ff];

   always_comb begin
      incoming.is_run   = (req_tuser[0] == ssf_pkg::MODE_RUN);
      incoming.position = req_tdata;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= incoming;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/ssf_back.sv =====
`default_nettype none
module ssf_back #(
   parameter int MAX_REQUESTS = 32
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        cmd_valid,
   output logic                       cmd_ready,
   input  ssf_pkg::cmd_type           cmd,
   output logic                       rsp_tvalid,
   input  wire                        rsp_tready,
   output logic [ssf_pkg::RSP_W-1:0]  rsp_tdata,
   output logic [ssf_pkg::STAT_W-1:0] rsp_tuser,
   output logic                       rsp_tlast
);

   localparam int IDX_W = $clog2(MAX_REQUESTS);
   localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
   localparam int PAD_W = ssf_pkg::RSP_W - ssf_pkg::POS_W - ssf_pkg::DIST_W - ssf_pkg::TOTAL_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [ssf_pkg::POS_W-1:0] store [MAX_REQUESTS];

   logic [1:0]                  state_ff, state_in;
   logic [MAX_REQUESTS-1:0]     pending_ff, pending_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [CNT_W-1:0]            remain_ff, remain_in;
   logic [CNT_W-1:0]            issue_ff, issue_in;
   logic [ssf_pkg::POS_W-1:0]   head_ff, head_in;
   logic [ssf_pkg::TOTAL_W-1:0] sum_ff, sum_in;

   logic                        rd_valid_ff;
   logic [IDX_W-1:0]            rd_idx_ff;
   logic [ssf_pkg::POS_W-1:0]   rd_data_ff;

   logic                        found_ff, found_in;
   logic [IDX_W-1:0]            best_idx_ff, best_idx_in;
   logic [ssf_pkg::DIST_W-1:0]  best_dist_ff, best_dist_in;
   logic [ssf_pkg::POS_W-1:0]   best_pos_ff, best_pos_in;

   logic                        out_valid_ff, out_valid_in;
   logic [ssf_pkg::POS_W-1:0]   out_pos_ff, out_pos_in;
   logic [ssf_pkg::DIST_W-1:0]  out_dist_ff, out_dist_in;
   logic [ssf_pkg::TOTAL_W-1:0] out_total_ff, out_total_in;
   logic [ssf_pkg::STAT_W-1:0]  out_status_ff, out_status_in;
   logic                        out_last_ff, out_last_in;

   logic                        out_free, take, issuing, load_ok;
   logic [ssf_pkg::DIST_W-1:0]  scan_dist;
   logic [ssf_pkg::TOTAL_W-1:0] new_sum;

   assign out_free  = !out_valid_ff || rsp_tready;
   assign cmd_ready = (state_ff == ST_IDLE) && out_free;
   assign take      = cmd_valid && cmd_ready;
   assign load_ok   = take && !cmd.is_run && (count_ff != CNT_W'(MAX_REQUESTS));
   assign issuing   = (state_ff == ST_SCAN) && (issue_ff < count_ff);
   assign scan_dist = (rd_data_ff >= head_ff) ? (rd_data_ff - head_ff)
                                              : (head_ff - rd_data_ff);
   assign new_sum   = sum_ff + ssf_pkg::TOTAL_W'(best_dist_ff);

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, out_total_ff, out_dist_ff, out_pos_ff};
   assign rsp_tuser  = out_status_ff;
   assign rsp_tlast  = out_last_ff;

   always_comb begin
      state_in      = state_ff;
      pending_in    = pending_ff;
      count_in      = count_ff;
      remain_in     = remain_ff;
      issue_in      = issuing ? issue_ff + CNT_W'(1) : issue_ff;
      head_in       = head_ff;
      sum_in        = sum_ff;
      found_in      = found_ff;
      best_idx_in   = best_idx_ff;
      best_dist_in  = best_dist_ff;
      best_pos_in   = best_pos_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_pos_in    = out_pos_ff;
      out_dist_in   = out_dist_ff;
      out_total_in  = out_total_ff;
      out_status_in = out_status_ff;
      out_last_in   = out_last_ff;

      // Compare stage of the scan: ties go to the later slot.
      if (rd_valid_ff && pending_ff[rd_idx_ff] &&
          (!found_ff || scan_dist <= best_dist_ff)) begin
         found_in     = 1'b1;
         best_idx_in  = rd_idx_ff;
         best_dist_in = scan_dist;
         best_pos_in  = rd_data_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               if (cmd.is_run) begin
                  head_in = cmd.position;
                  sum_in  = '0;
                  if (count_ff == '0) begin
                     out_valid_in  = 1'b1;
                     out_pos_in    = '0;
                     out_dist_in   = '0;
                     out_total_in  = '0;
                     out_status_in = ssf_pkg::STATUS_NOTHING;
                     out_last_in   = 1'b1;
                  end else begin
                     remain_in = count_ff;
                     issue_in  = '0;
                     found_in  = 1'b0;
                     state_in  = ST_SCAN;
                  end
               end else if (load_ok) begin
                  pending_in[count_ff[IDX_W-1:0]] = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  out_valid_in  = 1'b1;
                  out_pos_in    = '0;
                  out_dist_in   = '0;
                  out_total_in  = '0;
                  out_status_in = ssf_pkg::STATUS_FULL;
                  out_last_in   = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            if (!issuing && !rd_valid_ff) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_pos_in    = best_pos_ff;
               out_dist_in   = best_dist_ff;
               out_total_in  = new_sum;
               out_status_in = ssf_pkg::STATUS_SERVED;
               out_last_in   = (remain_ff == CNT_W'(1));
               pending_in[best_idx_ff] = 1'b0;
               head_in   = best_pos_ff;
               sum_in    = new_sum;
               remain_in = remain_ff - CNT_W'(1);
               if (remain_ff == CNT_W'(1)) begin
                  pending_in = '0;
                  count_in   = '0;
                  state_in   = ST_IDLE;
               end else begin
                  issue_in = '0;
                  found_in = 1'b0;
                  state_in = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pending_ff   <= '0;
         count_ff     <= '0;
         remain_ff    <= '0;
         issue_ff     <= '0;
         head_ff      <= '0;
         sum_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         issue_ff     <= issue_in;
         head_ff      <= head_in;
         sum_ff       <= sum_in;
         rd_valid_ff  <= issuing;
         found_ff     <= found_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff     <= issue_ff[IDX_W-1:0];
      best_idx_ff   <= best_idx_in;
      best_dist_ff  <= best_dist_in;
      best_pos_ff   <= best_pos_in;
      out_pos_ff    <= out_pos_in;
      out_dist_ff   <= out_dist_in;
      out_total_ff  <= out_total_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
   end

   // Request store: one write port for loads, one registered read port for the scan.
   always_ff @(posedge clock) begin
      if (load_ok) begin
         store[count_ff[IDX_W-1:0]] <= cmd.position;
      end
      if (issuing) begin
         rd_data_ff <= store[issue_ff[IDX_W-1:0]];
      end
   end

endmodule
`default_nettype wire

// ===== rtl/shortest_seek_first_scheduler.sv =====
// The engine takes a load only while idle; an accepted beat waits in the front-end queue
// until the engine takes it. A dropped load or an empty run returns a lone status beat.
// A run with N pending requests gives N beats, each after one pass of the store's single
// read port over all N loaded slots; ST_EMIT sends each beat once the output is free.
// Reset is synchronous and active high; it empties the queue, the store and the output.
`default_nettype none
module shortest_seek_first_scheduler #(
   parameter int MAX_REQUESTS = 32
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_tvalid,
   output logic                       req_tready,
   input  wire  [15:0]                req_tdata,  // position
   input  wire  [0:0]                 req_tuser,  // mode
   output logic                       rsp_tvalid,
   input  wire                        rsp_tready,
   output logic [55:0]                rsp_tdata,  // served_position, seek_distance,
                                                  // total_movement, zero pad
   output logic [1:0]                 rsp_tuser,  // status
   output logic                       rsp_tlast   // last
);

   logic             cmd_valid;
   logic             cmd_ready;
   ssf_pkg::cmd_type cmd;

   ssf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd)
   );

   ssf_back #(
      .MAX_REQUESTS (MAX_REQUESTS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

// ===== rtl/ssf_checker.sv =====
`default_nettype none
module ssf_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [55:0] rsp_tdata,
   input wire [1:0]  rsp_tuser,
   input wire        rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ssf_pkg::STATUS_SERVED) |-> rsp_tlast && (rsp_tdata == '0))
      else $error("status beat is not a lone zero beat");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == ssf_pkg::STATUS_SERVED) ||
                     (rsp_tuser == ssf_pkg::STATUS_FULL) ||
                     (rsp_tuser == ssf_pkg::STATUS_NOTHING))
      else $error("undefined status code");

   // The running total can never be smaller than the seek of its own step.
   a_total_covers_seek: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ssf_pkg::STATUS_SERVED) |->
         (rsp_tdata[53:32] >= {6'd0, rsp_tdata[31:16]}))
      else $error("total movement below seek distance");

endmodule

bind shortest_seek_first_scheduler ssf_checker u_ssf_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire
